>>> sv/uer_pkg.sv
package uer_pkg;

  // Tick rate and trigger pulse length
  localparam int unsigned TICKS_PER_SEC = 1000000;
  localparam int unsigned TRIG_TICKS    = 10;
  localparam int unsigned TRIG_W        = $clog2(TRIG_TICKS + 1);

  // Echo counter width and saturation value
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned COUNT_CAP   =
    ((1 << COUNT_WIDTH) - 1 < 65535) ? (1 << COUNT_WIDTH) - 1 : 65535;

  // Interval timer: longest period is 4095 s worth of ticks
  localparam longint unsigned PERIOD_MAX = 64'(4095) * 64'(TICKS_PER_SEC);
  localparam int unsigned     PERIOD_W   = $clog2(PERIOD_MAX);

  // Distance in cm * 256 = (duration * 17983) >> 12
  localparam int unsigned DIST_MUL   = 17983;
  localparam int unsigned DIST_SHIFT = 12;
  localparam int unsigned PROD_W     = DUR_W + 15;
  localparam int unsigned DIST_W     = 19;

  // Register reset values
  localparam logic [11:0]      INTERVAL_RST = 12'd1;
  localparam logic [DUR_W-1:0] MIN_DUR_RST  = 16'd116;
  localparam logic [DUR_W-1:0] MAX_DUR_RST  = 16'd23200;

  // Register map
  localparam int unsigned ADDR_W = 4;
  localparam logic [ADDR_W-1:0] ADDR_ENABLE   = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_INTERVAL = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_MIN_DUR  = 4'h8;
  localparam logic [ADDR_W-1:0] ADDR_MAX_DUR  = 4'hC;

  localparam int unsigned IN_W  = 8;
  localparam int unsigned OUT_W = 40;

  typedef struct packed {
    logic [DIST_W-1:0] distance_q8;
    logic [DUR_W-1:0]  echo_duration;
    logic              in_range;
    logic              echo_done;
    logic              trigger_skipped;
    logic              trig_level;
  } result_t;

endpackage

>>> sv/ultrasonic_echo_ranger_top.sv
// Ultrasonic echo ranger.
// Input stream: one request per microsecond tick, s_axis_tdata[0] is the
// sampled echo pin. Output stream: exactly one request per input request,
// carrying the trigger pin level for that tick, a skipped-trigger flag and,
// on the echo falling edge, the measurement (done flag, in-range flag,
// duration in ticks, distance in cm * 256).
// The result for a tick is registered and shown in the cycle after it is
// accepted. Throughput: one tick per cycle while not stalled; the single
// output register is refilled in the same cycle its result is taken.
// While enabled, a trigger pulse of TRIG_TICKS ticks is fired every
// interval_sec seconds unless an echo is still pending, in which case the
// firing is flagged as skipped.
// Reset clears all timers and echo tracking, disables the block and loads
// the default limits. When the receiver stalls, the result is held, tready
// drops, and the tick counters do not advance: time is counted in accepted
// ticks only.
// Configuration goes through the APB port; writes should only happen while
// no tick is in flight.
module ultrasonic_echo_ranger_top (
  input  logic                      clk,
  input  logic                      rst,
  // APB configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [uer_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // tick input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [uer_pkg::IN_W-1:0]  s_axis_tdata,  // [0] echo_level, [7:1] zero
  // result output
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [uer_pkg::OUT_W-1:0] m_axis_tdata   // [0] trig_level,
                                                   // [1] trigger_skipped,
                                                   // [2] echo_done, [3] in_range,
                                                   // [19:4] echo_duration,
                                                   // [38:20] distance_q8, [39] zero
);
  import uer_pkg::*;

  // configuration registers
  logic                enable;
  logic [11:0]         interval_sec;
  logic [DUR_W-1:0]    min_duration;
  logic [DUR_W-1:0]    max_duration;
  logic [PERIOD_W-1:0] period_m1;   // interval in ticks, minus one

  // measurement state
  logic [PERIOD_W-1:0]    interval_ticks;
  logic [TRIG_W-1:0]      trig_ticks_left;
  logic                   echo_prev;
  logic                   rise_seen;
  logic [COUNT_WIDTH-1:0] high_ticks;

  logic [PERIOD_W-1:0]    interval_ticks_next;
  logic [TRIG_W-1:0]      trig_ticks_left_next;
  logic                   echo_prev_next;
  logic                   rise_seen_next;
  logic [COUNT_WIDTH-1:0] high_ticks_next;

  result_t res;
  logic    cfg_wr;
  logic    s_fire;
  logic    echo;

  logic [11:0]         secs_wr;
  logic [PERIOD_W-1:0] period_wr;
  logic [DUR_W-1:0]    dur;
  logic [PROD_W-1:0]   prod;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // zero seconds behaves as one; the period is worked out at write time
  assign secs_wr   = (pwdata[11:0] == 12'd0) ? 12'd1 : pwdata[11:0];
  assign period_wr = PERIOD_W'(PERIOD_W'(secs_wr) * PERIOD_W'(TICKS_PER_SEC))
                     - PERIOD_W'(1);

  always_comb begin
    unique case (paddr)
      ADDR_ENABLE:   prdata = {31'd0, enable};
      ADDR_INTERVAL: prdata = {20'd0, interval_sec};
      ADDR_MIN_DUR:  prdata = {16'd0, min_duration};
      ADDR_MAX_DUR:  prdata = {16'd0, max_duration};
      default:       prdata = 32'd0;
    endcase
  end

  // output register: accept when empty or being drained
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign echo          = s_axis_tdata[0];

  assign dur  = DUR_W'(high_ticks);
  assign prod = PROD_W'(dur) * PROD_W'(DIST_MUL);

  always_comb begin
    logic [TRIG_W-1:0] trig_load;

    trig_load            = trig_ticks_left;
    interval_ticks_next  = interval_ticks;
    trig_ticks_left_next = trig_ticks_left;
    echo_prev_next       = echo;
    rise_seen_next       = rise_seen;
    high_ticks_next      = high_ticks;
    res                  = '0;

    if (!enable) begin
      interval_ticks_next  = '0;
      trig_ticks_left_next = '0;
      rise_seen_next       = 1'b0;
      high_ticks_next      = '0;
    end else begin
      // interval timer; a pending echo suppresses the trigger
      if (interval_ticks >= period_m1) begin
        interval_ticks_next = '0;
        if (rise_seen) begin
          res.trigger_skipped = 1'b1;
        end else begin
          trig_load = TRIG_W'(TRIG_TICKS);
        end
      end else begin
        interval_ticks_next = interval_ticks + PERIOD_W'(1);
      end

      trig_ticks_left_next = trig_load;
      if (trig_load != '0) begin
        res.trig_level       = 1'b1;
        trig_ticks_left_next = trig_load - TRIG_W'(1);
      end

      // echo edge tracking
      if (echo && !echo_prev) begin
        rise_seen_next  = 1'b1;
        high_ticks_next = COUNT_WIDTH'(1);
      end else if (echo && rise_seen) begin
        if (high_ticks < COUNT_WIDTH'(COUNT_CAP)) begin
          high_ticks_next = high_ticks + COUNT_WIDTH'(1);
        end
      end else if (!echo && echo_prev) begin
        res.echo_done = 1'b1;
        if (rise_seen) begin
          res.echo_duration = dur;
          if (dur >= min_duration && dur <= max_duration) begin
            res.in_range    = 1'b1;
            res.distance_q8 = prod[DIST_SHIFT +: DIST_W];
          end
        end
        rise_seen_next  = 1'b0;
        high_ticks_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable          <= 1'b0;
      interval_sec    <= INTERVAL_RST;
      period_m1       <= PERIOD_W'(TICKS_PER_SEC - 1);
      min_duration    <= MIN_DUR_RST;
      max_duration    <= MAX_DUR_RST;
      interval_ticks  <= '0;
      trig_ticks_left <= '0;
      echo_prev       <= 1'b0;
      rise_seen       <= 1'b0;
      high_ticks      <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr)
          ADDR_ENABLE:   enable <= pwdata[0];
          ADDR_INTERVAL: begin
            interval_sec <= pwdata[11:0];
            period_m1    <= period_wr;
          end
          ADDR_MIN_DUR:  min_duration <= pwdata[DUR_W-1:0];
          ADDR_MAX_DUR:  max_duration <= pwdata[DUR_W-1:0];
          default: ;
        endcase
      end

      if (s_fire) begin
        interval_ticks  <= interval_ticks_next;
        trig_ticks_left <= trig_ticks_left_next;
        echo_prev       <= echo_prev_next;
        rise_seen       <= rise_seen_next;
        high_ticks      <= high_ticks_next;
        m_axis_tvalid   <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid   <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_axis_tdata <= OUT_W'(res);
    end
  end

endmodule
